// ===== design/srpc_pkg.sv =====
package srpc_pkg;

  // Line and channel geometry
  localparam int LINE_LENGTH   = 10;
  localparam int NUM_RELAYS    = 11;
  localparam int NUM_PWM       = 7;
  localparam int MAX_DIGIT_POS = 5;

  localparam int POS_W     = $clog2(LINE_LENGTH);
  localparam int RLY_IDX_W = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  localparam int CHAN_W    = 4;
  localparam int TIMER_W   = 16;

  localparam logic [TIMER_W-1:0] PULSE_TICKS_RESET = 16'd10000;

  // Command queue depth
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

  // Character codes
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_A  = 8'h61;
  localparam logic [7:0] CHAR_Z  = 8'h7A;

  // Result kinds
  localparam logic KIND_RELAY = 1'b0;
  localparam logic KIND_PWM   = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_RELAY,
    OP_PWM
  } op_e;

  // One classified command, front to back
  typedef struct packed {
    op_e               op;
    logic [CHAN_W-1:0] chan;
    logic [7:0]        value;
  } cmd_t;

  // One pin update
  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] channel;
    logic              pin_level;
    logic              pwm_enable;
    logic [7:0]        duty;
    logic              last;
  } result_t;

  function automatic result_t relay_result(logic [CHAN_W-1:0] ch, logic level, logic last);
    result_t r;
    r.kind       = KIND_RELAY;
    r.channel    = ch;
    r.pin_level  = level;
    r.pwm_enable = 1'b0;
    r.duty       = 8'd0;
    r.last       = last;
    return r;
  endfunction

  // Duty is inverted; both extremes park the pin and stop the generator
  function automatic result_t pwm_result(logic [CHAN_W-1:0] ch, logic [7:0] value);
    result_t r;
    logic [7:0] d;
    d            = ~value;
    r.kind       = KIND_PWM;
    r.channel    = ch;
    r.duty       = d;
    r.last       = 1'b1;
    if (d == 8'd0) begin
      r.pin_level  = 1'b1;
      r.pwm_enable = 1'b0;
    end else if (d == 8'hFF) begin
      r.pin_level  = 1'b0;
      r.pwm_enable = 1'b0;
    end else begin
      r.pin_level  = 1'b0;
      r.pwm_enable = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== design/srpc_if.sv =====
interface srpc_in_if import srpc_pkg::*;;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_byte;

  modport source (output valid, output mode, output char_byte, input ready);
  modport sink   (input valid, input mode, input char_byte, output ready);
endinterface

interface srpc_out_if import srpc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAN_W-1:0] channel;
  logic              pin_level;
  logic              pwm_enable;
  logic [7:0]        duty;
  logic              last;

  modport source (output valid, output kind, output channel, output pin_level,
                  output pwm_enable, output duty, output last, input ready);
  modport sink   (input valid, input kind, input channel, input pin_level,
                  input pwm_enable, input duty, input last, output ready);
endinterface

// ===== design/serial_relay_pwm_commander_core.sv =====
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    mode, char_byte
// out_o     out  valid/ready    kind, channel, pin_level, pwm_enable, duty, last
// cfg       in   pulse_ticks_we_i  pulse_ticks_i (16 bit)
//
// A line end with a valid command letter queues one command, as does any
// tick-mode character. A tick walks all NUM_RELAYS timers, one per cycle
// while no expiry waits on a full output register, then flushes. Input
// stalls only when the 4-entry command queue is full; the back stalls on
// a full output register. Async active-low reset, no clearing pass.
module serial_relay_pwm_commander_core import srpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pulse_ticks_we_i,
  input  logic [TIMER_W-1:0] pulse_ticks_i,
  srpc_in_if.sink            in_i,
  srpc_out_if.source         out_o
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  srpc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  srpc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .head_o  (cmd_head),
    .full_o  (full),
    .empty_o (empty)
  );

  srpc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pulse_ticks_we_i (pulse_ticks_we_i),
    .pulse_ticks_i    (pulse_ticks_i),
    .cmd_i            (cmd_head),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_o            (out_o)
  );

endmodule

// ===== design/srpc_front.sv =====
module srpc_front import srpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  srpc_in_if.sink  in_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       head_q, head_d;
  logic [7:0]       num_q, num_d;
  logic             bad_q, bad_d;

  logic       accept;
  logic [7:0] c;
  logic [7:0] head;
  logic [7:0] idx;
  logic       line_end;
  logic       is_digit;
  logic [7:0] value;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign c          = in_i.char_byte;

  assign line_end = (pos_q == POS_W'(LINE_LENGTH - 1)) || (c == CHAR_NL);
  assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  assign head     = (pos_q == '0) ? c : head_q;
  assign idx      = head - CHAR_A;
  assign value    = bad_q ? 8'd0 : num_q;

  // Line assembly: keep the command letter, fold digits in as they arrive
  // (num*10 + d mod 256 matches the right-to-left weighted sum)
  always_comb begin
    pos_d  = pos_q;
    head_d = head_q;
    num_d  = num_q;
    bad_d  = bad_q;
    if (accept && !in_i.mode) begin
      if (pos_q == '0) begin
        head_d = c;
        num_d  = 8'd0;
        bad_d  = 1'b0;
      end else if (pos_q <= POS_W'(MAX_DIGIT_POS) && c != CHAR_NL) begin
        num_d = {num_q[4:0], 3'b000} + {num_q[6:0], 1'b0} + (c - CHAR_0);
        if (!is_digit) bad_d = 1'b1;
      end
      pos_d = line_end ? '0 : pos_q + 1'b1;
    end
  end

  // Classification of the item into a queued command
  always_comb begin
    push_o       = 1'b0;
    cmd_o.op     = OP_TICK;
    cmd_o.chan   = '0;
    cmd_o.value  = value;
    if (accept) begin
      if (in_i.mode) begin
        push_o = 1'b1;
      end else if (line_end && head >= CHAR_A && head <= CHAR_Z) begin
        if (idx < 8'(NUM_RELAYS)) begin
          push_o     = 1'b1;
          cmd_o.op   = OP_RELAY;
          cmd_o.chan = idx[CHAN_W-1:0];
        end else if (idx < 8'(NUM_RELAYS + NUM_PWM)) begin
          push_o     = 1'b1;
          cmd_o.op   = OP_PWM;
          cmd_o.chan = CHAN_W'(idx - 8'(NUM_RELAYS));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    num_q  <= num_d;
    bad_q  <= bad_d;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(LINE_LENGTH - 1))
    else $error("write position beyond line");
`endif

endmodule

// ===== design/srpc_cmd_fifo.sv =====
module srpc_cmd_fifo import srpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                 mem_q [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;

  assign full_o  = (count_q == (CMD_PTR_W + 1)'(CMD_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");
`endif

endmodule

// ===== design/srpc_back.sv =====
module srpc_back import srpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pulse_ticks_we_i,
  input  logic [TIMER_W-1:0]  pulse_ticks_i,
  input  cmd_t                cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  srpc_out_if.source          out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_FLUSH
  } state_e;

  state_e                 state_q, state_d;
  logic [RLY_IDX_W-1:0]   idx_q, idx_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [RLY_IDX_W-1:0]   pend_ch_q, pend_ch_d;
  logic [TIMER_W-1:0]     timers_q [NUM_RELAYS];
  logic [TIMER_W-1:0]     pulse_ticks_q;
  result_t                res_q, res_d;
  logic                   out_valid_q, out_valid_d;

  logic                   can_load;
  logic                   load;
  logic                   tmr_we;
  logic [RLY_IDX_W-1:0]   tmr_addr;
  logic [TIMER_W-1:0]     tmr_wdata;
  logic [TIMER_W-1:0]     tmr_cur;
  logic                   hit;

  assign can_load = !out_valid_q || out_o.ready;
  assign tmr_cur  = timers_q[idx_q];
  // timer about to become 1 on this decrement
  assign hit      = (tmr_cur == TIMER_W'(2));

  // Command sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_ch_d    = pend_ch_q;
    res_d        = res_q;
    load         = 1'b0;
    pop_o        = 1'b0;
    tmr_we       = 1'b0;
    tmr_addr     = idx_q;
    tmr_wdata    = tmr_cur - 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.op)
            OP_TICK: begin
              pop_o        = 1'b1;
              idx_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = ST_TICK;
            end
            OP_RELAY: begin
              if (can_load) begin
                pop_o = 1'b1;
                load  = 1'b1;
                res_d = relay_result(cmd_i.chan, cmd_i.value == 8'd0, 1'b1);
                if (cmd_i.value == 8'd2) begin
                  tmr_we    = 1'b1;
                  tmr_addr  = cmd_i.chan[RLY_IDX_W-1:0];
                  tmr_wdata = pulse_ticks_q;
                end
              end
            end
            OP_PWM: begin
              if (can_load) begin
                pop_o = 1'b1;
                load  = 1'b1;
                res_d = pwm_result(cmd_i.chan, cmd_i.value);
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_TICK: begin
        // a new expiry pushes the previous one out, never marked last
        if (!(hit && pend_valid_q && !can_load)) begin
          if (tmr_cur != '0) tmr_we = 1'b1;
          if (hit) begin
            if (pend_valid_q) begin
              load  = 1'b1;
              res_d = relay_result(CHAN_W'(pend_ch_q), 1'b1, 1'b0);
            end
            pend_valid_d = 1'b1;
            pend_ch_d    = idx_q;
          end
          if (idx_q == RLY_IDX_W'(NUM_RELAYS - 1)) state_d = ST_FLUSH;
          else idx_d = idx_q + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_load) begin
          load         = 1'b1;
          res_d        = relay_result(CHAN_W'(pend_ch_q), 1'b1, 1'b1);
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      pend_valid_q  <= 1'b0;
      pend_ch_q     <= '0;
      out_valid_q   <= 1'b0;
      res_q         <= '0;
      pulse_ticks_q <= PULSE_TICKS_RESET;
      for (int i = 0; i < NUM_RELAYS; i++) timers_q[i] <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      pend_ch_q    <= pend_ch_d;
      out_valid_q  <= out_valid_d;
      res_q        <= res_d;
      if (pulse_ticks_we_i) pulse_ticks_q <= pulse_ticks_i;
      if (tmr_we) timers_q[tmr_addr] <= tmr_wdata;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = res_q.kind;
  assign out_o.channel    = res_q.channel;
  assign out_o.pin_level  = res_q.pin_level;
  assign out_o.pwm_enable = res_q.pwm_enable;
  assign out_o.duty       = res_q.duty;
  assign out_o.last       = res_q.last;

`ifndef SYNTHESIS
  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_TICK || state_q == ST_FLUSH))
    else $error("pending expiry outside timer walk");
  a_no_pop_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK || state_q == ST_FLUSH) |-> !pop_o)
    else $error("command taken during timer walk");
`endif

endmodule
